// File: hdl/staged_brake_duty_ramp_unit_macros.svh
// Assertion macros for the staged brake duty ramp unit.
// Included by files that carry concurrent checks; needs no package.
`ifndef STAGED_BRAKE_DUTY_RAMP_UNIT_MACROS_SVH
`define STAGED_BRAKE_DUTY_RAMP_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SBDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SBDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sbdr_pkg.sv
// Shared types, constants and register codes for the staged brake duty ramp unit.
// No dependencies; every other file of the block but the macro header refers to this package.
package sbdr_pkg;

    localparam int DUTY_BITS     = 8;
    localparam int SUM_BITS      = DUTY_BITS + 1;
    localparam int OUT_DUTY_BITS = 8;
    localparam int REQ_TYPE_BITS = 2;
    localparam int DIST_BITS     = 16;
    localparam int TIME_BITS     = 32;
    localparam int IVL_BITS      = 16;
    localparam int STAGE_BITS    = 3;
    localparam int LIMIT_BITS    = 8;
    localparam int DEC_BITS      = 7;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;

    typedef enum logic [REQ_TYPE_BITS-1:0] {
        REQ_STAGED = 2'd0,
        REQ_RAPID  = 2'd1,
        REQ_ACCEL  = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        REG_BRAKE_STAGES = 3'd0,
        REG_BRAKE_IVL    = 3'd1,
        REG_RAPID_IVL    = 3'd2,
        REG_ACCEL_IVL    = 3'd3,
        REG_MAX_DUTY     = 3'd4,
        REG_START_DUTY   = 3'd5
    } t_reg_idx;

    // register reset values
    localparam logic [STAGE_BITS-1:0] STAGES_RST     = 3'd3;
    localparam logic [IVL_BITS-1:0]   BRAKE_IVL_RST  = 16'd100;
    localparam logic [IVL_BITS-1:0]   RAPID_IVL_RST  = 16'd50;
    localparam logic [IVL_BITS-1:0]   ACCEL_IVL_RST  = 16'd100;
    localparam logic [LIMIT_BITS-1:0] MAX_DUTY_RST   = 8'd255;
    localparam logic [LIMIT_BITS-1:0] START_DUTY_RST = 8'd0;

    localparam logic [DEC_BITS-1:0] RAPID_STEP = 7'd115;
    localparam logic [DEC_BITS-1:0] ACCEL_STEP = 7'd20;

    // band thresholds in Q12.4 and their decrements
    localparam logic [DIST_BITS-1:0] T3_B0 = 16'(200 * 16);
    localparam logic [DIST_BITS-1:0] T3_B1 = 16'(450 * 16);
    localparam logic [DIST_BITS-1:0] T3_B2 = 16'(700 * 16);
    localparam logic [DEC_BITS-1:0]  D3_B0 = 7'd90;
    localparam logic [DEC_BITS-1:0]  D3_B1 = 7'd75;
    localparam logic [DEC_BITS-1:0]  D3_B2 = 7'd35;

    localparam logic [DIST_BITS-1:0] T4_B0 = 16'(250 * 16);
    localparam logic [DIST_BITS-1:0] T4_B1 = 16'(450 * 16);
    localparam logic [DIST_BITS-1:0] T4_B2 = 16'(600 * 16);
    localparam logic [DIST_BITS-1:0] T4_B3 = 16'(750 * 16);
    localparam logic [DEC_BITS-1:0]  D4_B0 = 7'd83;
    localparam logic [DEC_BITS-1:0]  D4_B1 = 7'd68;
    localparam logic [DEC_BITS-1:0]  D4_B2 = 7'd48;
    localparam logic [DEC_BITS-1:0]  D4_B3 = 7'd38;

    localparam logic [DIST_BITS-1:0] T5_B0 = 16'(250 * 16);
    localparam logic [DIST_BITS-1:0] T5_B1 = 16'(400 * 16);
    localparam logic [DIST_BITS-1:0] T5_B2 = 16'(600 * 16);
    localparam logic [DIST_BITS-1:0] T5_B3 = 16'(740 * 16);
    localparam logic [DIST_BITS-1:0] T5_B4 = 16'(820 * 16);
    localparam logic [DEC_BITS-1:0]  D5_B0 = 7'd88;
    localparam logic [DEC_BITS-1:0]  D5_B1 = 7'd64;
    localparam logic [DEC_BITS-1:0]  D5_B2 = 7'd45;
    localparam logic [DEC_BITS-1:0]  D5_B3 = 7'd37;
    localparam logic [DEC_BITS-1:0]  D5_B4 = 7'd28;

    typedef struct packed {
        logic [STAGE_BITS-1:0] brake_stages;
        logic [IVL_BITS-1:0]   brake_ivl;
        logic [IVL_BITS-1:0]   rapid_ivl;
        logic [IVL_BITS-1:0]   accel_ivl;
        logic [LIMIT_BITS-1:0] max_duty;
    } t_cfg;

    typedef struct packed {
        logic [REQ_TYPE_BITS-1:0] req_type;
        logic [DIST_BITS-1:0]     distance;
        logic [TIME_BITS-1:0]     now_ms;
    } t_item;

    typedef struct packed {
        logic [OUT_DUTY_BITS-1:0] duty_out;
        logic                     updated;
    } t_res;

endpackage

// File: hdl/sbdr_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on sbdr_pkg for field widths.
interface sbdr_req_if;
    logic                                valid;
    logic                                ready;
    logic [sbdr_pkg::REQ_TYPE_BITS-1:0] req_type;
    logic [sbdr_pkg::DIST_BITS-1:0]     distance;
    logic [sbdr_pkg::TIME_BITS-1:0]     now_ms;

    modport source (output valid, req_type, distance, now_ms, input ready);
    modport sink   (input valid, req_type, distance, now_ms, output ready);
endinterface

interface sbdr_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [sbdr_pkg::OUT_DUTY_BITS-1:0] duty_out;
    logic                                updated;

    modport source (output valid, duty_out, updated, input ready);
    modport sink   (input valid, duty_out, updated, output ready);
endinterface

// File: hdl/sbdr_cfg_regs.sv
// APB-style configuration register file for the staged brake duty ramp unit.
// Depends on sbdr_pkg for register codes, reset values and the t_cfg struct.
module sbdr_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sbdr_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [sbdr_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [sbdr_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready,
    output sbdr_pkg::t_cfg                      o_cfg
);

    logic [sbdr_pkg::STAGE_BITS-1:0] r_stages;
    logic [sbdr_pkg::IVL_BITS-1:0]   r_brake_ivl;
    logic [sbdr_pkg::IVL_BITS-1:0]   r_rapid_ivl;
    logic [sbdr_pkg::IVL_BITS-1:0]   r_accel_ivl;
    logic [sbdr_pkg::LIMIT_BITS-1:0] r_max_duty;
    logic [sbdr_pkg::LIMIT_BITS-1:0] r_start_duty;
    logic                            w_wr;
    sbdr_pkg::t_reg_idx              w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = sbdr_pkg::t_reg_idx'(paddr[sbdr_pkg::APB_ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stages     <= sbdr_pkg::STAGES_RST;
            r_brake_ivl  <= sbdr_pkg::BRAKE_IVL_RST;
            r_rapid_ivl  <= sbdr_pkg::RAPID_IVL_RST;
            r_accel_ivl  <= sbdr_pkg::ACCEL_IVL_RST;
            r_max_duty   <= sbdr_pkg::MAX_DUTY_RST;
            r_start_duty <= sbdr_pkg::START_DUTY_RST;
        end else if (w_wr) begin
            case (w_idx)
                sbdr_pkg::REG_BRAKE_STAGES: r_stages     <= pwdata[sbdr_pkg::STAGE_BITS-1:0];
                sbdr_pkg::REG_BRAKE_IVL:    r_brake_ivl  <= pwdata[sbdr_pkg::IVL_BITS-1:0];
                sbdr_pkg::REG_RAPID_IVL:    r_rapid_ivl  <= pwdata[sbdr_pkg::IVL_BITS-1:0];
                sbdr_pkg::REG_ACCEL_IVL:    r_accel_ivl  <= pwdata[sbdr_pkg::IVL_BITS-1:0];
                sbdr_pkg::REG_MAX_DUTY:     r_max_duty   <= pwdata[sbdr_pkg::LIMIT_BITS-1:0];
                sbdr_pkg::REG_START_DUTY:   r_start_duty <= pwdata[sbdr_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            sbdr_pkg::REG_BRAKE_STAGES: prdata = 32'(r_stages);
            sbdr_pkg::REG_BRAKE_IVL:    prdata = 32'(r_brake_ivl);
            sbdr_pkg::REG_RAPID_IVL:    prdata = 32'(r_rapid_ivl);
            sbdr_pkg::REG_ACCEL_IVL:    prdata = 32'(r_accel_ivl);
            sbdr_pkg::REG_MAX_DUTY:     prdata = 32'(r_max_duty);
            sbdr_pkg::REG_START_DUTY:   prdata = 32'(r_start_duty);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.brake_stages = r_stages;
    assign o_cfg.brake_ivl    = r_brake_ivl;
    assign o_cfg.rapid_ivl    = r_rapid_ivl;
    assign o_cfg.accel_ivl    = r_accel_ivl;
    assign o_cfg.max_duty     = r_max_duty;

endmodule

// File: hdl/sbdr_band_lut.sv
// Distance band lookup: maps a Q12.4 distance to a staged brake decrement.
// Depends on sbdr_pkg for the band thresholds and decrements.
module sbdr_band_lut (
    input  logic [sbdr_pkg::STAGE_BITS-1:0] i_stages,
    input  logic [sbdr_pkg::DIST_BITS-1:0]  i_distance,
    output logic [sbdr_pkg::DEC_BITS-1:0]   o_dec
);

    logic [sbdr_pkg::DEC_BITS-1:0] w_dec3;
    logic [sbdr_pkg::DEC_BITS-1:0] w_dec4;
    logic [sbdr_pkg::DEC_BITS-1:0] w_dec5;

    always_comb begin
        if      (i_distance <= sbdr_pkg::T3_B0) w_dec3 = sbdr_pkg::D3_B0;
        else if (i_distance <= sbdr_pkg::T3_B1) w_dec3 = sbdr_pkg::D3_B1;
        else if (i_distance <= sbdr_pkg::T3_B2) w_dec3 = sbdr_pkg::D3_B2;
        else                                    w_dec3 = '0;

        if      (i_distance <= sbdr_pkg::T4_B0) w_dec4 = sbdr_pkg::D4_B0;
        else if (i_distance <= sbdr_pkg::T4_B1) w_dec4 = sbdr_pkg::D4_B1;
        else if (i_distance <= sbdr_pkg::T4_B2) w_dec4 = sbdr_pkg::D4_B2;
        else if (i_distance <= sbdr_pkg::T4_B3) w_dec4 = sbdr_pkg::D4_B3;
        else                                    w_dec4 = '0;

        if      (i_distance <= sbdr_pkg::T5_B0) w_dec5 = sbdr_pkg::D5_B0;
        else if (i_distance <= sbdr_pkg::T5_B1) w_dec5 = sbdr_pkg::D5_B1;
        else if (i_distance <= sbdr_pkg::T5_B2) w_dec5 = sbdr_pkg::D5_B2;
        else if (i_distance <= sbdr_pkg::T5_B3) w_dec5 = sbdr_pkg::D5_B3;
        else if (i_distance <= sbdr_pkg::T5_B4) w_dec5 = sbdr_pkg::D5_B4;
        else                                    w_dec5 = '0;

        // stage counts below three act as three, above five as five
        if (i_stages inside {[3'd5:3'd7]}) begin
            o_dec = w_dec5;
        end else if (i_stages == 3'd4) begin
            o_dec = w_dec4;
        end else begin
            o_dec = w_dec3;
        end
    end

endmodule

// File: hdl/sbdr_duty_core.sv
// Duty state and update logic: interval checks, saturating brake and accelerate.
// Depends on sbdr_pkg and instantiates sbdr_band_lut.
module sbdr_duty_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sbdr_pkg::t_cfg i_cfg,
    input  logic           i_fire,
    input  sbdr_pkg::t_item i_item,
    output sbdr_pkg::t_res o_res
);

    logic [sbdr_pkg::DUTY_BITS-1:0] r_duty,       n_duty;
    logic [sbdr_pkg::TIME_BITS-1:0] r_last_brake, n_last_brake;
    logic [sbdr_pkg::TIME_BITS-1:0] r_last_accel, n_last_accel;

    sbdr_pkg::t_req_type            w_type;
    logic [sbdr_pkg::DEC_BITS-1:0]  w_band_dec;
    logic [sbdr_pkg::DEC_BITS-1:0]  w_dec;
    logic [sbdr_pkg::DUTY_BITS-1:0] w_dec_ext;
    logic [sbdr_pkg::DUTY_BITS-1:0] w_sub;
    logic [sbdr_pkg::IVL_BITS-1:0]  w_brk_ivl;
    logic [sbdr_pkg::TIME_BITS-1:0] w_brk_el;
    logic [sbdr_pkg::TIME_BITS-1:0] w_acc_el;
    logic                           w_brk_ok;
    logic                           w_acc_ok;
    logic [sbdr_pkg::DUTY_BITS-1:0] w_max_ext;
    logic [sbdr_pkg::SUM_BITS-1:0]  w_sum;
    logic [sbdr_pkg::DUTY_BITS-1:0] w_acc;
    logic                           w_upd;

    assign w_type = sbdr_pkg::t_req_type'(i_item.req_type);

    sbdr_band_lut u_band (
        .i_stages   (i_cfg.brake_stages),
        .i_distance (i_item.distance),
        .o_dec      (w_band_dec)
    );

    // both brake kinds share one stamp, each with its own interval
    assign w_dec     = (w_type == sbdr_pkg::REQ_RAPID) ? sbdr_pkg::RAPID_STEP : w_band_dec;
    assign w_brk_ivl = (w_type == sbdr_pkg::REQ_RAPID) ? i_cfg.rapid_ivl : i_cfg.brake_ivl;
    assign w_dec_ext = sbdr_pkg::DUTY_BITS'(w_dec);
    assign w_sub     = (r_duty > w_dec_ext) ? (r_duty - w_dec_ext) : '0;

    // wrapping elapsed time
    assign w_brk_el = i_item.now_ms - r_last_brake;
    assign w_acc_el = i_item.now_ms - r_last_accel;
    assign w_brk_ok = w_brk_el >= sbdr_pkg::TIME_BITS'(w_brk_ivl);
    assign w_acc_ok = w_acc_el >= sbdr_pkg::TIME_BITS'(i_cfg.accel_ivl);

    // at or above the limit hold duty, never pull it down to the limit
    assign w_max_ext = sbdr_pkg::DUTY_BITS'(i_cfg.max_duty);
    assign w_sum     = {1'b0, r_duty} + sbdr_pkg::SUM_BITS'(sbdr_pkg::ACCEL_STEP);
    assign w_acc     = (r_duty >= w_max_ext) ? r_duty :
                       (w_sum > {1'b0, w_max_ext}) ? w_max_ext :
                       w_sum[sbdr_pkg::DUTY_BITS-1:0];

    always_comb begin
        n_duty       = r_duty;
        n_last_brake = r_last_brake;
        n_last_accel = r_last_accel;
        w_upd        = 1'b0;
        case (w_type)
            sbdr_pkg::REQ_STAGED, sbdr_pkg::REQ_RAPID: begin
                if (w_brk_ok) begin
                    w_upd        = 1'b1;
                    n_last_brake = i_item.now_ms;
                    n_duty       = w_sub;
                end
            end
            sbdr_pkg::REQ_ACCEL: begin
                if (w_acc_ok) begin
                    w_upd        = 1'b1;
                    n_last_accel = i_item.now_ms;
                    n_duty       = w_acc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty       <= sbdr_pkg::DUTY_BITS'(sbdr_pkg::START_DUTY_RST);
            r_last_brake <= '0;
            r_last_accel <= '0;
        end else if (i_fire) begin
            r_duty       <= n_duty;
            r_last_brake <= n_last_brake;
            r_last_accel <= n_last_accel;
        end
    end

    assign o_res.duty_out = n_duty[sbdr_pkg::OUT_DUTY_BITS-1:0];
    assign o_res.updated  = w_upd;

endmodule

// File: hdl/staged_brake_duty_ramp_unit.sv
// Staged brake duty ramp unit: top level with input and result registers.
// Depends on sbdr_pkg, sbdr_if, sbdr_cfg_regs, sbdr_duty_core and the macro header.
//
// Usage:
//   i_req carries commands (req_type, distance in Q12.4, now_ms); o_rsp returns
//   one result per command (duty_out, updated). Both are valid/ready channels;
//   a transfer happens on a rising edge with valid and ready high.
//   The APB-style port (psel..pready) holds six registers at byte address 4*i;
//   writes land in the access cycle, pready is tied high, write only when idle.
// Timing:
//   A transferred command sits in the input register; its result is registered
//   as it advances and is offered on o_rsp from then on. The duty update is one
//   pass of band lookup plus saturating add or subtract, so while o_rsp is ready
//   a new command is taken every cycle, one result per cycle sustained.
// Reset (synchronous, active low): registers take their default values, duty
//   goes to the start_duty default, both timestamps to zero, both stages empty.
// Stall: while o_rsp is not ready the result holds; the input register still
//   fills, and i_req.ready drops only when both stages are full.
`include "staged_brake_duty_ramp_unit_macros.svh"

module staged_brake_duty_ramp_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    sbdr_req_if.sink                            i_req,
    sbdr_rsp_if.source                          o_rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sbdr_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [sbdr_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [sbdr_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready
);

    sbdr_pkg::t_cfg  w_cfg;
    sbdr_pkg::t_item r_in;
    logic            r_in_valid;
    sbdr_pkg::t_res  r_out;
    logic            r_out_valid;
    sbdr_pkg::t_res  w_res;
    logic            w_advance;
    logic            w_in_xfer;

    sbdr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // advance when the result slot is free or being drained this cycle
    assign w_advance   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_advance;
    assign w_in_xfer   = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in.req_type <= i_req.req_type;
            r_in.distance <= i_req.distance;
            r_in.now_ms   <= i_req.now_ms;
        end
    end

    sbdr_duty_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_fire  (w_advance),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.duty_out = r_out.duty_out;
    assign o_rsp.updated  = r_out.updated;

    `SBDR_ASSERT_NOW(a_ready_low_only_when_full, i_clk, i_rst_n, !i_req.ready, r_in_valid && r_out_valid && !o_rsp.ready, "input blocked while a stage is free")
    `SBDR_ASSERT_NEXT(a_advance_gives_result, i_clk, i_rst_n, w_advance, r_out_valid, "advanced command produced no result")
    `SBDR_ASSERT_NOW(a_unused_kind_no_update, i_clk, i_rst_n, w_advance && (r_in.req_type != sbdr_pkg::REQ_STAGED) && (r_in.req_type != sbdr_pkg::REQ_RAPID) && (r_in.req_type != sbdr_pkg::REQ_ACCEL), !w_res.updated, "unused command kind reported an update")

endmodule
